>>> rtl/core/mprq_pkg.sv
// Shared types and codes for the multi-policy ready queue scheduler.
`default_nettype none
package mprq_pkg;

  localparam logic [1:0] CMD_ENQ    = 2'd0;
  localparam logic [1:0] CMD_SELECT = 2'd1;
  localparam logic [1:0] CMD_CHANGE = 2'd2;

  localparam logic [1:0] POL_RR  = 2'd0;
  localparam logic [1:0] POL_LOT = 2'd1;
  localparam logic [1:0] POL_RT  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTHING  = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam int RND_W = 31;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUT,
    OP_DROP,
    OP_MOVE
  } op_t;

  typedef struct packed {
    logic [7:0] task_id;
    logic [1:0] policy;
    logic [7:0] tickets;
    logic [7:0] prio;
  } entry_t;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       walk_step;
    logic       apply;
    op_t        op;
    logic [1:0] st;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] sel;
    logic       occ_zero;
    logic       full;
    logic       sum_zero;
    logic       div_last;
    logic       walk_stop;
    logic       walk_hit;
  } stat_t;

endpackage
`default_nettype wire

>>> rtl/core/mprq_datapath.sv
// Ready table, lottery modulo unit, table walk and result register.
`default_nettype none
module mprq_datapath import mprq_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int IW = 4,
  parameter int CW = 5,
  parameter int SW = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ctrl_t            ctrl,
  output stat_t                 stat,
  input  wire logic [1:0]       cmd,
  input  wire logic [7:0]       task_id,
  input  wire logic [1:0]       policy,
  input  wire logic [7:0]       tickets,
  input  wire logic [7:0]       priority_req,
  input  wire logic [1:0]       select_policy,
  input  wire logic [RND_W-1:0] random_value,
  output logic [1:0]            res_status,
  output logic [7:0]            res_picked,
  output logic [CW-1:0]         res_count,
  output logic [SW-1:0]         res_total
);

  entry_t           tbl [TABLE_DEPTH];
  logic [CW-1:0]    occ;
  logic [SW-1:0]    lsum;
  logic [1:0]       cmd_q;
  logic [7:0]       id_q;
  logic [1:0]       pol_q;
  logic [7:0]       tk_q;
  logic [7:0]       pr_q;
  logic [1:0]       sel_q;
  logic [RND_W-1:0] rnd_sh;
  logic [SW-1:0]    rem;
  logic [4:0]       dcnt;
  logic [IW-1:0]    idx;
  logic [SW-1:0]    acc;
  logic [IW-1:0]    best;
  logic [7:0]       best_pr;
  logic [IW-1:0]    pos;

  entry_t           cur;
  entry_t           pe;
  logic [SW:0]      rem_sh;
  logic [SW-1:0]    acc_next;
  logic             last;
  logic             hit_now;
  logic             rt_better;
  logic             mode_change;
  logic             mode_lot;
  logic [CW-1:0]    occ_next;
  logic [SW-1:0]    lsum_next;
  logic [SW-1:0]    old_tk;
  logic [SW-1:0]    new_tk;

  always_comb begin
    cur         = tbl[idx];
    pe          = tbl[pos];
    rem_sh      = {rem, rnd_sh[RND_W-1]};
    mode_change = (cmd_q == CMD_CHANGE);
    mode_lot    = (sel_q == POL_LOT);
    last        = ((CW'(idx) + CW'(1)) == occ);
    acc_next    = acc + ((cur.policy == POL_LOT) ? SW'(cur.tickets) : SW'(0));
    rt_better   = (idx == '0) || ((cur.policy == POL_RT) && (cur.prio > best_pr));
    if (mode_change) begin
      hit_now = (cur.task_id == id_q);
    end else if (mode_lot) begin
      hit_now = (cur.policy == POL_LOT) && (acc_next > rem);
    end else begin
      hit_now = 1'b0;
    end
    old_tk = (pe.policy == POL_LOT) ? SW'(pe.tickets) : SW'(0);
    unique case (ctrl.op)
      OP_PUT: begin
        occ_next  = occ + CW'(1);
        lsum_next = lsum + ((pol_q == POL_LOT) ? SW'(tk_q) : SW'(0));
        new_tk    = '0;
      end
      OP_DROP: begin
        occ_next  = occ - CW'(1);
        lsum_next = lsum - old_tk;
        new_tk    = '0;
      end
      OP_MOVE: begin
        new_tk    = (pol_q == POL_LOT) ? SW'(pe.tickets) : SW'(0);
        occ_next  = occ;
        lsum_next = lsum - old_tk + new_tk;
      end
      default: begin
        occ_next  = occ;
        lsum_next = lsum;
        new_tk    = '0;
      end
    endcase
    stat.cmd       = cmd_q;
    stat.sel       = sel_q;
    stat.occ_zero  = (occ == '0);
    stat.full      = (occ >= CW'(TABLE_DEPTH));
    stat.sum_zero  = (lsum == '0);
    stat.div_last  = (dcnt == 5'(RND_W - 1));
    stat.walk_stop = hit_now || last;
    stat.walk_hit  = (mode_change || mode_lot) ? hit_now : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      lsum <= '0;
    end else if (ctrl.apply) begin
      occ  <= occ_next;
      lsum <= lsum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q   <= cmd;
      id_q    <= task_id;
      pol_q   <= policy;
      tk_q    <= tickets;
      pr_q    <= priority_req;
      sel_q   <= select_policy;
      rnd_sh  <= random_value;
      rem     <= '0;
      dcnt    <= '0;
      idx     <= '0;
      acc     <= '0;
      best    <= '0;
      best_pr <= '0;
      pos     <= '0;
    end
    if (ctrl.div_step) begin
      if (rem_sh >= {1'b0, lsum}) begin
        rem <= SW'(rem_sh - {1'b0, lsum});
      end else begin
        rem <= SW'(rem_sh);
      end
      rnd_sh <= {rnd_sh[RND_W-2:0], 1'b0};
      dcnt   <= dcnt + 5'd1;
    end
    if (ctrl.walk_step) begin
      idx <= idx + IW'(1);
      acc <= acc_next;
      if (mode_change || mode_lot) begin
        if (hit_now) begin
          pos <= idx;
        end
      end else if (rt_better) begin
        best    <= idx;
        best_pr <= cur.prio;
        pos     <= idx;
      end else begin
        pos <= best;
      end
    end
    if (ctrl.apply) begin
      res_status <= ctrl.st;
      res_picked <= (ctrl.op == OP_DROP) ? pe.task_id : 8'd0;
      res_count  <= occ_next;
      res_total  <= lsum_next;
      if (ctrl.op == OP_PUT) begin
        tbl[occ[IW-1:0]] <= '{task_id: id_q, policy: pol_q, tickets: tk_q, prio: pr_q};
      end
      if ((ctrl.op == OP_DROP) || (ctrl.op == OP_MOVE)) begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          if (k >= int'(pos)) begin
            if ((ctrl.op == OP_MOVE) && (k == int'(occ) - 1)) begin
              tbl[k] <= '{task_id: id_q, policy: pol_q, tickets: pe.tickets, prio: pe.prio};
            end else if (k + 1 < TABLE_DEPTH) begin
              tbl[k] <= tbl[k + 1];
            end
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/mprq_controller.sv
// Command sequencer for the scheduler: decode, modulo, walk and apply.
`default_nettype none
module mprq_controller import mprq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output ctrl_t      ctrl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_WALK,
    S_APPLY
  } state_t;

  state_t     state;
  op_t        op_q;
  logic [1:0] st_q;

  always_comb begin
    in_ready       = (state == S_IDLE);
    ctrl.load      = in_valid && (state == S_IDLE);
    ctrl.div_step  = (state == S_DIV);
    ctrl.walk_step = (state == S_WALK);
    ctrl.apply     = (state == S_APPLY) && (!out_valid || out_ready);
    ctrl.op        = op_q;
    ctrl.st        = st_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      op_q      <= OP_NONE;
      st_q      <= ST_OK;
    end else begin
      if (ctrl.apply) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          state <= S_APPLY;
          op_q  <= OP_NONE;
          st_q  <= ST_OK;
          priority case (stat.cmd)
            CMD_ENQ: begin
              if (stat.full) begin
                st_q <= ST_FULL;
              end else begin
                op_q <= OP_PUT;
              end
            end
            CMD_SELECT: begin
              if (stat.occ_zero) begin
                st_q <= ST_NOTHING;
              end else begin
                priority case (stat.sel)
                  POL_RR:  op_q <= OP_DROP;
                  POL_LOT: begin
                    if (stat.sum_zero) begin
                      st_q <= ST_NOTHING;
                    end else begin
                      state <= S_DIV;
                    end
                  end
                  POL_RT:  state <= S_WALK;
                  default: st_q <= ST_NOTHING;
                endcase
              end
            end
            CMD_CHANGE: begin
              if (stat.occ_zero) begin
                st_q <= ST_NOTFOUND;
              end else begin
                state <= S_WALK;
              end
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (stat.div_last) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (stat.walk_stop) begin
            state <= S_APPLY;
            if (stat.walk_hit) begin
              op_q <= (stat.cmd == CMD_CHANGE) ? OP_MOVE : OP_DROP;
              st_q <= ST_OK;
            end else begin
              op_q <= OP_NONE;
              st_q <= (stat.cmd == CMD_CHANGE) ? ST_NOTFOUND : ST_NOTHING;
            end
          end
        end
        S_APPLY: begin
          if (ctrl.apply) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/multi_policy_ready_queue_scheduler_unit.sv
// Top level: stream ports around the scheduler controller and datapath.
// Enqueue and round robin go from decode to apply; realtime and change walk the queued
// entries first, and lottery runs a bit-serial modulo of the random value, then walks.
// Throughput: one command at a time; the next is taken once the result is registered.
// Reset: synchronous, clears table occupancy, ticket total and the output valid.
// Table contents are not cleared; entries are written before they are read.
`default_nettype none
module multi_policy_ready_queue_scheduler_unit import mprq_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // cmd, task_id, policy, tickets, priority_req, select_policy, random_value
  input  wire logic [63:0]            s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // status, picked_id, entry_count, ticket_total
  output logic [((22 + $clog2(TABLE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int IW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int SW    = 8 + IW;
  localparam int OUT_W = ((22 + CW + 7) / 8) * 8;

  ctrl_t         ctrl;
  stat_t         stat;
  logic [1:0]    res_status;
  logic [7:0]    res_picked;
  logic [CW-1:0] res_count;
  logic [SW-1:0] res_total;

  mprq_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  mprq_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IW          (IW),
    .CW          (CW),
    .SW          (SW)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .stat          (stat),
    .cmd           (s_tdata[1:0]),
    .task_id       (s_tdata[9:2]),
    .policy        (s_tdata[11:10]),
    .tickets       (s_tdata[19:12]),
    .priority_req  (s_tdata[27:20]),
    .select_policy (s_tdata[29:28]),
    .random_value  (s_tdata[60:30]),
    .res_status    (res_status),
    .res_picked    (res_picked),
    .res_count     (res_count),
    .res_total     (res_total)
  );

  assign m_tdata = OUT_W'({12'(res_total), res_count, res_picked, res_status});

endmodule
`default_nettype wire

>>> rtl/core/mprq_checker.sv
// Port-level checks for the scheduler and their binding to the top level.
`default_nettype none
module mprq_checker import mprq_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result transaction dropped while stalled");

  a_picked_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[9:2] == 8'd0))
    else $error("picked id set on failed command");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == ST_FULL) |-> (m_tdata[14:10] == 5'd16))
    else $error("full status with table not full");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind multi_policy_ready_queue_scheduler_unit mprq_checker u_mprq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

>>> test/mprq_checker.sv
// Checker: watches both streams, predicts each scheduler result and compares it.
module mprq_scoreboard import mprq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int OW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  input  wire logic          s_tready,
  input  wire logic [63:0]   s_tdata,
  input  wire logic          m_tvalid,
  input  wire logic          m_tready,
  input  wire logic [OW-1:0] m_tdata,
  output int                 mismatches,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] total;
    logic [4:0]  count;
    logic [7:0]  picked;
    logic [1:0]  status;
  } verdict_t;

  entry_t   ready_tab[DEPTH];
  int       occ;
  int       lot_sum;
  verdict_t verdicts[$];

  assign pending = verdicts.size();

  function automatic void remove_at(int pos);
    if (ready_tab[pos].policy == POL_LOT) lot_sum -= ready_tab[pos].tickets;
    for (int i = pos; i + 1 < occ; i++) ready_tab[i] = ready_tab[i + 1];
    occ--;
  endfunction

  function automatic void append(entry_t e);
    ready_tab[occ] = e;
    occ++;
    if (e.policy == POL_LOT) lot_sum += e.tickets;
  endfunction

  function automatic verdict_t schedule(logic [63:0] d);
    logic [1:0]  cmd;
    logic [1:0]  sel;
    logic [30:0] rnd;
    entry_t      e;
    verdict_t    v;
    int          pos;
    int          acc;
    int          draw;
    bit          hit;
    cmd = d[1:0];
    e.task_id = d[9:2];
    e.policy = d[11:10];
    e.tickets = d[19:12];
    e.prio = d[27:20];
    sel = d[29:28];
    rnd = d[60:30];
    v = '0;
    v.status = ST_OK;
    hit = 0;
    pos = 0;
    if (cmd == CMD_ENQ) begin
      if (occ >= DEPTH) v.status = ST_FULL;
      else append(e);
    end else if (cmd == CMD_SELECT) begin
      if (occ > 0) begin
        if (sel == POL_RR) hit = 1;
        else if (sel == POL_LOT && lot_sum != 0) begin
          draw = int'(rnd % lot_sum);
          acc = 0;
          for (int i = 0; i < occ && !hit; i++)
            if (ready_tab[i].policy == POL_LOT) begin
              acc += ready_tab[i].tickets;
              if (acc > draw) begin
                hit = 1;
                pos = i;
              end
            end
        end else if (sel == POL_RT) begin
          hit = 1;
          for (int i = 0; i < occ; i++)
            if (ready_tab[i].policy == POL_RT && ready_tab[i].prio > ready_tab[pos].prio)
              pos = i;
        end
      end
      if (hit) begin
        v.picked = ready_tab[pos].task_id;
        remove_at(pos);
      end else v.status = ST_NOTHING;
    end else if (cmd == CMD_CHANGE) begin
      for (int i = 0; i < occ && !hit; i++)
        if (ready_tab[i].task_id == e.task_id) begin
          hit = 1;
          pos = i;
        end
      if (hit) begin
        e.tickets = ready_tab[pos].tickets;
        e.prio = ready_tab[pos].prio;
        remove_at(pos);
        append(e);
      end else v.status = ST_NOTFOUND;
    end
    v.count = 5'(occ);
    v.total = 12'(lot_sum);
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (rst) begin
      occ = 0;
      lot_sum = 0;
      mismatches <= 0;
      verdicts.delete();
    end else begin
      if (s_tvalid && s_tready) verdicts.push_back(schedule(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata[26:0];
        if (verdicts.size() == 0) begin
          if (mismatches < 10) $display("unexpected transaction: %h", got);
          mismatches <= mismatches + 1;
        end else begin
          want = verdicts.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("mismatch: status %0d/%0d picked %0d/%0d count %0d/%0d total %0d/%0d",
                       want.status, got.status, want.picked, got.picked,
                       want.count, got.count, want.total, got.total);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

>>> test/multi_policy_ready_queue_scheduler_unit_tb.sv
// Testbench top: drives scheduler commands with bursts and stalls and reports the verdict.
module multi_policy_ready_queue_scheduler_unit_tb;
  import mprq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int OW = ((22 + $clog2(DEPTH + 1) + 7) / 8) * 8;

  logic          clk;
  logic          rst;
  logic          s_tvalid;
  logic          s_tready;
  logic [63:0]   s_tdata;
  logic          m_tvalid;
  logic          m_tready;
  logic [OW-1:0] m_tdata;
  int            mismatches;
  int            pending;
  bit            hold_off;
  bit            sends_done;

  multi_policy_ready_queue_scheduler_unit #(.TABLE_DEPTH(DEPTH)) u_top (.*);

  mprq_scoreboard #(.DEPTH(DEPTH), .OW(OW)) u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .mismatches, .pending
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [63:0] pack_cmd(logic [1:0] cmd, logic [7:0] id, logic [1:0] pol,
                                           logic [7:0] tk, logic [7:0] pr, logic [1:0] sel,
                                           logic [30:0] rnd);
    return {3'b0, rnd, sel, pr, tk, pol, id, cmd};
  endfunction

  // offer a transaction and hold it until accepted; valid stays up for the next one
  task automatic send(logic [63:0] d);
    s_tvalid <= 1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // random gap before about one transaction in four, none otherwise for a burst
  task automatic send_gapped(logic [63:0] d);
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    send(d);
  endtask

  function automatic logic [63:0] rand_cmd();
    logic [1:0] cmd;
    logic [7:0] id;
    int         r;
    r = $urandom_range(0, 99);
    cmd = r < 45 ? CMD_ENQ : r < 80 ? CMD_SELECT : r < 97 ? CMD_CHANGE : 2'd3;
    id = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 20));
    return pack_cmd(cmd, id, 2'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2)),
                    8'($urandom), 8'($urandom), 2'($urandom_range(0, 12) == 0 ? 3 :
                    $urandom_range(0, 2)), 31'($urandom));
  endfunction

  // receiver stall pattern, with one long hold-off on request
  initial begin
    m_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) m_tready <= 0;
      else m_tready <= ($urandom_range(0, 4) != 0);
    end
  end

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    hold_off = 0;
    sends_done = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, every command and special case
    send(pack_cmd(CMD_SELECT, 0, 0, 0, 0, POL_RR, 0));
    send(pack_cmd(CMD_SELECT, 0, 0, 0, 0, POL_LOT, 31'h7fffffff));
    send(pack_cmd(CMD_CHANGE, 8'hff, POL_RT, 0, 0, 0, 0));
    send(pack_cmd(CMD_ENQ, 8'hff, POL_LOT, 8'hff, 8'hff, 0, 0));
    send(pack_cmd(CMD_ENQ, 0, POL_RR, 0, 0, 0, 0));
    send(pack_cmd(CMD_ENQ, 7, POL_RT, 3, 8'hff, 0, 0));
    send(pack_cmd(CMD_ENQ, 7, POL_LOT, 0, 9, 0, 0));
    send(pack_cmd(CMD_ENQ, 9, 2'd3, 5, 200, 0, 0));
    send(pack_cmd(2'd3, 8'haa, 2'd3, 8'hff, 8'hff, 2'd3, 31'h7fffffff));
    send(pack_cmd(CMD_SELECT, 0, 0, 0, 0, 2'd3, 0));
    send(pack_cmd(CMD_CHANGE, 7, POL_LOT, 0, 0, 0, 0));
    send(pack_cmd(CMD_CHANGE, 8'hff, POL_RR, 0, 0, 0, 0));
    send(pack_cmd(CMD_SELECT, 0, 0, 0, 0, POL_LOT, 31'h7fffffff));
    send(pack_cmd(CMD_SELECT, 0, 0, 0, 0, POL_RT, 0));
    send(pack_cmd(CMD_SELECT, 0, 0, 0, 0, POL_LOT, 0));
    send(pack_cmd(CMD_SELECT, 0, 0, 0, 0, POL_RR, 0));
    for (int i = 0; i < 17; i++)
      send(pack_cmd(CMD_ENQ, 8'(i), 2'(i % 3), 8'(i * 15), 8'(i * 13), 0, 0));
    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 20; i++) send(rand_cmd());
    join
    // pause until everything has come back
    s_tvalid <= 0;
    @(posedge clk);
    wait (pending == 0);
    for (int i = 0; i < 1400; i++) send_gapped(rand_cmd());
    s_tvalid <= 0;
    sends_done = 1;
  end

  initial begin
    wait (sends_done);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
